// File: design/olist_pkg.sv
// Shared types and constants for the ordered list engine.
`default_nettype none
package olist_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int POS_W        = 8;
  localparam int WORD_W       = 32;
  localparam int STATUS_W     = 3;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_LOCATE = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Per-cycle controls broadcast to every cell.
  typedef struct packed {
    logic ins_en;   // shift up from the insert point, load the new word there
    logic del_en;   // shift down from the delete point
    logic rd_mode;  // search wave matches on position rather than value
  } cell_ctrl_t;

  // Search result travelling down the chain, one cell a cycle.
  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  fpos;
    logic [WORD_W-1:0] rval;
  } wave_t;

endpackage
`default_nettype wire

// File: design/olist_cell.sv
// One list slot: holds a word, shifts with its neighbours and passes the search wave on.
`default_nettype none
module olist_cell
  import olist_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 8
) (
  input  wire  logic              clk,
  input  wire  cell_ctrl_t        ctrl,
  input  wire  logic [POS_W-1:0]  pos,
  input  wire  logic [WORD_W-1:0] value,
  input  wire  logic [CNT_W-1:0]  count,
  input  wire  logic [WORD_W-1:0] left_data,
  input  wire  logic [WORD_W-1:0] right_data,
  input  wire  wave_t             wave_in,
  output logic [WORD_W-1:0]       data,
  output wave_t                   wave_out
);

  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CMP_W-1:0] SLOT = CMP_W'(IDX + 1);
  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [CMP_W-1:0] pos_ext;
  logic             hit;
  logic [WORD_W-1:0] data_next;
  wave_t            wave_next;

  assign pos_ext = CMP_W'(pos);

  always_comb begin
    if (ctrl.rd_mode) begin
      hit = (SLOT == pos_ext);
    end else begin
      hit = (data == value) && (IDX_C < count);
    end
  end

  always_comb begin
    data_next = data;
    if (ctrl.ins_en) begin
      if (SLOT == pos_ext) begin
        data_next = value;
      end else if (SLOT > pos_ext) begin
        data_next = left_data;
      end
    end else if (ctrl.del_en) begin
      if (SLOT >= pos_ext) begin
        data_next = right_data;
      end
    end
  end

  always_comb begin
    wave_next = wave_in;
    if (!wave_in.found && hit) begin
      wave_next.found = 1'b1;
      wave_next.fpos  = SLOT[POS_W-1:0];
      wave_next.rval  = data;
    end
  end

  always_ff @(posedge clk) begin
    data     <= data_next;
    wave_out <= wave_next;
  end

endmodule
`default_nettype wire

// File: design/ordered_list_engine.sv
// Top level of the ordered list engine: request control and the chain of list cells.
//
//  channel | dir | tdata fields (low bit up)                           | tuser/tlast
//  --------+-----+-----------------------------------------------------+------------
//  s_axis  | in  | op[1:0] position[9:2] value[41:10], zero to 48 bits | none
//  m_axis  | out | status[2:0] found_position[10:3] read_value[42:11]  | none
//          |     | list_length[50:43], zero to 56 bits                 |
//
// Insert and delete go from the execute state to the finish state, which loads the output
// register once it is free, the whole chain shifting at once; read and locate also pass
// the scan state, where the search wave walks the chain one cell a cycle to the last cell.
// One request is in flight: the next is accepted the cycle after the result is loaded
// into the output register, even while it waits to be taken.
// rst clears the control and the length; list words are not cleared.
`default_nettype none
module ordered_list_engine
  import olist_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        s_tvalid,
  output logic              s_tready,
  input  wire  logic [47:0] s_tdata,   // op[1:0], position[9:2], value[41:10]
  output logic              m_tvalid,
  input  wire  logic        m_tready,
  output logic [55:0]       m_tdata    // status[2:0], found_position[10:3],
                                       // read_value[42:11], list_length[50:43]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SCN_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
  localparam logic [SCN_W-1:0] SCN_END = SCN_W'(CAPACITY - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  // Held request
  op_t               req_op;
  logic [POS_W-1:0]  req_pos;
  logic [WORD_W-1:0] req_val;

  logic [CNT_W-1:0]  count, count_next;
  logic [SCN_W-1:0]  scan_cnt;

  // Result waiting for the output register
  status_t           res_status, res_status_next;
  logic [POS_W-1:0]  res_fpos, res_fpos_next;
  logic [WORD_W-1:0] res_rval, res_rval_next;

  // Output register
  status_t           out_status;
  logic [POS_W-1:0]  out_fpos;
  logic [WORD_W-1:0] out_rval;
  logic [POS_W-1:0]  out_len;

  cell_ctrl_t        ctrl;
  logic [WORD_W-1:0] cell_data [CAPACITY];
  wave_t             cell_wave [CAPACITY];

  logic [CMP_W-1:0]  pos_ext, n_ext;
  logic              out_free;
  wave_t             tail;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign pos_ext  = CMP_W'(req_pos);
  assign n_ext    = CMP_W'(count);
  assign tail     = cell_wave[CAPACITY-1];

  assign m_tdata = {5'd0, out_len, out_rval, out_fpos, out_status};

  // Decide the request; shifts happen only in the execute cycle.
  always_comb begin
    state_next      = state;
    count_next      = count;
    res_status_next = res_status;
    res_fpos_next   = res_fpos;
    res_rval_next   = res_rval;
    ctrl.ins_en     = 1'b0;
    ctrl.del_en     = 1'b0;
    ctrl.rd_mode    = (req_op == OP_READ);

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_fpos_next = '0;
        res_rval_next = '0;
        state_next    = S_FINISH;
        case (req_op)
          OP_INSERT: begin
            if (count == CAP_C) begin
              res_status_next = ST_FULL;
            end else if (req_pos == '0 || pos_ext > n_ext + CMP_W'(1)) begin
              res_status_next = ST_BAD_POS;
            end else begin
              res_status_next = ST_OK;
              ctrl.ins_en     = 1'b1;
              count_next      = count + CNT_W'(1);
            end
          end
          OP_DELETE: begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
            end else if (req_pos == '0 || pos_ext > n_ext) begin
              res_status_next = ST_BAD_POS;
            end else begin
              res_status_next = ST_OK;
              ctrl.del_en     = 1'b1;
              count_next      = count - CNT_W'(1);
            end
          end
          default: begin
            state_next = S_SCAN;
          end
        endcase
      end
      S_SCAN: begin
        if (scan_cnt == SCN_END) begin
          state_next = S_FINISH;
          if (req_op == OP_READ) begin
            res_fpos_next = '0;
            if (req_pos == '0 || pos_ext > n_ext) begin
              res_status_next = ST_BAD_POS;
              res_rval_next   = '0;
            end else begin
              res_status_next = ST_OK;
              res_rval_next   = tail.rval;
            end
          end else begin
            res_rval_next = '0;
            if (tail.found) begin
              res_status_next = ST_OK;
              res_fpos_next   = tail.fpos;
            end else begin
              res_status_next = ST_NOT_FOUND;
              res_fpos_next   = '0;
            end
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      scan_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      // Advance the scan counter only while the wave walks the chain
      if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + SCN_W'(1);
      end else begin
        scan_cnt <= '0;
      end
      if (state == S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_op  <= op_t'(s_tdata[1:0]);
      req_pos <= s_tdata[9:2];
      req_val <= s_tdata[41:10];
    end
    res_status <= res_status_next;
    res_fpos   <= res_fpos_next;
    res_rval   <= res_rval_next;
    if (state == S_FINISH && out_free) begin
      out_status <= res_status;
      out_fpos   <= res_fpos;
      out_rval   <= res_rval;
      out_len    <= POS_W'(count);
    end
  end

  // Cell chain: words shift between neighbours, the search wave moves toward the tail
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] left_d, right_d;
    wave_t             w_in;

    if (i == 0) begin : g_head
      assign left_d = cell_data[0];
      assign w_in   = '0;
    end else begin : g_body
      assign left_d = cell_data[i-1];
      assign w_in   = cell_wave[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    olist_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (req_pos),
      .value      (req_val),
      .count      (count),
      .left_data  (left_d),
      .right_data (right_d),
      .wave_in    (w_in),
      .data       (cell_data[i]),
      .wave_out   (cell_wave[i])
    );
  end

endmodule
`default_nettype wire
